@@ rtl/lkv_pkg.sv @@
// shared types and constants for the linked key-value table
package lkv_pkg;

	// request codes
	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_SEARCH = 2'd1,
		MODE_REMOVE = 2'd2
	} mode_t;

	// register map (byte address)
	localparam logic [1:0] ADDR_ABSENT = 2'd0;

	// width of the entry count on the result port
	localparam int COUNT_OUT_BITS = 5;

	// one request as it arrives
	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] key;
		logic signed [31:0] new_value;
	} req_t;

	// one result as it leaves
	typedef struct packed {
		logic signed [31:0]        result_value;
		logic                      found;
		logic                      full_res;
		logic [COUNT_OUT_BITS-1:0] entry_count;
		logic                      is_empty;
	} res_t;

	// control part of the token that travels along the row of cells
	typedef struct packed {
		logic       valid;
		logic [1:0] mode;
		logic       hit;
		logic       placed;
	} tok_ctl_t;

endpackage

@@ rtl/lkv_cell.sv @@
// one slot of the table: holds an entry and passes the request token on
module lkv_cell #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32,
	parameter int CW         = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lkv_pkg::tok_ctl_t      tin_ctl,
	input  logic [KEY_BITS-1:0]    tin_key,
	input  logic [VALUE_BITS-1:0]  tin_val,
	input  logic [VALUE_BITS-1:0]  tin_old,
	input  logic [CW-1:0]          tin_left,
	input  logic [KEY_BITS-1:0]    nb_key,
	input  logic [VALUE_BITS-1:0]  nb_val,
	output lkv_pkg::tok_ctl_t      tout_ctl,
	output logic [KEY_BITS-1:0]    tout_key,
	output logic [VALUE_BITS-1:0]  tout_val,
	output logic [VALUE_BITS-1:0]  tout_old,
	output logic [CW-1:0]          tout_left,
	output logic [KEY_BITS-1:0]    ent_key,
	output logic [VALUE_BITS-1:0]  ent_val
);
	import lkv_pkg::*;

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	tok_ctl_t              ctl_q;
	logic [KEY_BITS-1:0]   tkey_q;
	logic [VALUE_BITS-1:0] tval_q;
	logic [VALUE_BITS-1:0] old_q;
	logic [CW-1:0]         left_q;

	logic                  occ;
	logic                  match;
	tok_ctl_t              ctl_d;
	logic [VALUE_BITS-1:0] old_d;
	logic                  key_we;
	logic                  val_we;
	logic [KEY_BITS-1:0]   key_d;
	logic [VALUE_BITS-1:0] val_d;

	// entries stay packed at the front, so a slot is in use while the count has not run out
	assign occ   = (tin_left != '0);
	assign match = occ && (key_q == tin_key);

	// per-slot action for the passing request
	always_comb begin
		ctl_d  = tin_ctl;
		old_d  = tin_old;
		key_we = 1'b0;
		val_we = 1'b0;
		key_d  = tin_key;
		val_d  = tin_val;
		if (tin_ctl.valid) begin
			unique case (tin_ctl.mode)
				MODE_ADD: begin
					if (!tin_ctl.hit && !tin_ctl.placed) begin
						if (match) begin
							ctl_d.hit = 1'b1;
							old_d     = value_q;
							val_we    = 1'b1;
						end else if (!occ) begin
							ctl_d.placed = 1'b1;
							key_we       = 1'b1;
							val_we       = 1'b1;
						end
					end
				end
				MODE_SEARCH: begin
					if (!tin_ctl.hit && match) begin
						ctl_d.hit = 1'b1;
						old_d     = value_q;
					end
				end
				MODE_REMOVE: begin
					// close the gap: every slot from the hit onward takes its neighbor's entry
					key_d = nb_key;
					val_d = nb_val;
					if (tin_ctl.hit) begin
						key_we = 1'b1;
						val_we = 1'b1;
					end else if (match) begin
						ctl_d.hit = 1'b1;
						old_d     = value_q;
						key_we    = 1'b1;
						val_we    = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (key_we) key_q <= key_d;
		if (val_we) value_q <= val_d;
	end

	// token control hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_d;
		end
	end

	// token payload hand-off
	always_ff @(posedge clk) begin
		tkey_q <= tin_key;
		tval_q <= tin_val;
		old_q  <= old_d;
		left_q <= occ ? tin_left - 1'b1 : '0;
	end

	assign tout_ctl  = ctl_q;
	assign tout_key  = tkey_q;
	assign tout_val  = tval_q;
	assign tout_old  = old_q;
	assign tout_left = left_q;
	assign ent_key   = key_q;
	assign ent_val   = value_q;

endmodule

@@ rtl/linked_key_value_table_top.sv @@
// top level of the linked key-value table: request entry, row of slots, result and registers
//
// Usage:
//   A request (add/replace, search or remove) is taken at a rising edge with start high and
//   busy low. busy then stays high until the result strobe rises; one request is worked at a
//   time.
//   The request travels as a token down a row of SLOTS cells, one cell per cycle, each cell
//   comparing its stored key and acting on a hit. Entries are kept packed at the front of the
//   row in insertion order: an add of a new key lands in the first free cell, a remove shifts
//   the later entries one cell forward as the token passes.
//   On its way the request passes the entry register, the row of slots and the result register.
//   busy falls as the strobe rises, so the next request can be taken at the edge that ends the
//   strobe cycle.
//   The result sits on res for exactly one cycle with res_valid high; the receiver cannot
//   stall it.
//   Configuration: APB port, absent_value at byte address 0, to be written only while idle;
//   the user must keep to this, as the block itself does not enforce it.
//   Reset clears the table to empty, the entry count to zero and absent_value to zero; stored
//   keys and values are not cleared and are never read before being written.
module linked_key_value_table_top #(
	parameter int SLOTS      = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lkv_pkg::req_t req,
	output logic          res_valid,
	output lkv_pkg::res_t res,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [1:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import lkv_pkg::*;

	localparam int CW = $clog2(SLOTS + 1);

	logic                    busy_q;
	logic                    res_valid_q;
	res_t                    res_q;
	logic [CW-1:0]           count_q;
	logic signed [31:0]      absent_q;

	tok_ctl_t                head_ctl_q;
	logic [KEY_BITS-1:0]     head_key_q;
	logic [VALUE_BITS-1:0]   head_val_q;
	logic [CW-1:0]           head_left_q;

	tok_ctl_t                chain_ctl  [SLOTS+1];
	logic [KEY_BITS-1:0]     chain_key  [SLOTS+1];
	logic [VALUE_BITS-1:0]   chain_val  [SLOTS+1];
	logic [VALUE_BITS-1:0]   chain_old  [SLOTS+1];
	logic [CW-1:0]           chain_left [SLOTS+1];
	logic [KEY_BITS-1:0]     ent_key    [SLOTS];
	logic [VALUE_BITS-1:0]   ent_val    [SLOTS];

	logic                    accept;
	logic signed [63:0]      key_ext;
	logic [63:0]             val_ext;
	tok_ctl_t                last;
	logic signed [VALUE_BITS-1:0] old_s;
	logic [CW-1:0]           count_d;
	res_t                    res_d;
	logic                    cfg_we;

	assign accept = start && !busy_q;

	// key keeps the low bits of its sign extension, value the low bits as given
	assign key_ext = 64'(req.key);
	assign val_ext = 64'(unsigned'(req.new_value));

	// token entry register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_ctl_q <= '0;
		end else begin
			head_ctl_q.valid  <= accept;
			head_ctl_q.mode   <= req.mode;
			head_ctl_q.hit    <= 1'b0;
			head_ctl_q.placed <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_key_q  <= key_ext[KEY_BITS-1:0];
			head_val_q  <= val_ext[VALUE_BITS-1:0];
			head_left_q <= count_q;
		end
	end

	assign chain_ctl[0]  = head_ctl_q;
	assign chain_key[0]  = head_key_q;
	assign chain_val[0]  = head_val_q;
	assign chain_old[0]  = '0;
	assign chain_left[0] = head_left_q;

	// row of slots
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic [KEY_BITS-1:0]   nb_key;
		logic [VALUE_BITS-1:0] nb_val;

		if (i < SLOTS - 1) begin : g_mid
			assign nb_key = ent_key[i+1];
			assign nb_val = ent_val[i+1];
		end else begin : g_end
			assign nb_key = '0;
			assign nb_val = '0;
		end

		lkv_cell #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS),
			.CW         (CW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tin_ctl   (chain_ctl[i]),
			.tin_key   (chain_key[i]),
			.tin_val   (chain_val[i]),
			.tin_old   (chain_old[i]),
			.tin_left  (chain_left[i]),
			.nb_key    (nb_key),
			.nb_val    (nb_val),
			.tout_ctl  (chain_ctl[i+1]),
			.tout_key  (chain_key[i+1]),
			.tout_val  (chain_val[i+1]),
			.tout_old  (chain_old[i+1]),
			.tout_left (chain_left[i+1]),
			.ent_key   (ent_key[i]),
			.ent_val   (ent_val[i])
		);
	end

	// result from the token leaving the last slot
	assign last  = chain_ctl[SLOTS];
	assign old_s = chain_old[SLOTS];

	always_comb begin
		count_d = count_q;
		if (last.mode == MODE_ADD && last.placed) begin
			count_d = count_q + 1'b1;
		end else if (last.mode == MODE_REMOVE && last.hit && count_q != '0) begin
			count_d = count_q - 1'b1;
		end
		res_d.result_value = last.hit ? 32'(old_s) : absent_q;
		res_d.found        = last.hit;
		res_d.full_res     = (last.mode == MODE_ADD) && !last.hit && !last.placed;
		res_d.entry_count  = COUNT_OUT_BITS'(count_d);
		res_d.is_empty     = (count_d == '0);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			res_valid_q <= last.valid;
			if (last.valid) begin
				busy_q  <= 1'b0;
				count_q <= count_d;
			end else if (accept) begin
				busy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (last.valid) res_q <= res_d;
	end

	assign busy      = busy_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// configuration register
	assign cfg_we = psel && penable && pwrite && (paddr == ADDR_ABSENT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			absent_q <= '0;
		end else if (cfg_we) begin
			absent_q <= pwdata;
		end
	end

	assign prdata = (paddr == ADDR_ABSENT) ? absent_q : '0;
	assign pready = 1'b1;

endmodule

@@ rtl/lkv_checker.sv @@
// port-level checks for the linked key-value table, bound to the top level
module lkv_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          res_valid,
	input lkv_pkg::res_t res
);
	import lkv_pkg::*;

	// an accepted request keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after request");

	// busy drops exactly with the result strobe
	a_fall_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> res_valid)
		else $error("busy dropped without a result");

	// never two results back to back
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> !res_valid)
		else $error("result strobe longer than one cycle");

	// a result comes only when the request is finished
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !busy)
		else $error("result while still busy");

	// a rejected add never reports a hit
	a_found_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.found && res.full_res))
		else $error("found and full together");

endmodule

bind linked_key_value_table_top lkv_checker u_lkv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.res_valid (res_valid),
	.res       (res)
);

@@ tb/linked_key_value_table_top_tb.sv @@
// self-checking testbench for the linked key-value table top level
`timescale 1ns / 1ps

module linked_key_value_table_top_tb;
	import lkv_pkg::*;

	localparam int TABLE_SLOTS = 16;
	localparam logic [4:0] NO_SLOT = 5'd16;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int POOL_SIZE = 24;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 150;

	// shadow of the table that predicts each answer and checks the block against it
	class kv_table_scoreboard;
		logic [31:0] key_mem [TABLE_SLOTS];
		logic [31:0] val_mem [TABLE_SLOTS];
		logic [4:0] link_mem [TABLE_SLOTS];
		logic [4:0] chain_head;
		logic [4:0] free_head;
		int stored_count;
		logic [31:0] absent_value;
		res_t expected_answers [$];
		int mismatch_count;

		function new();
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				key_mem[i] = '0;
				val_mem[i] = '0;
				link_mem[i] = (i + 1 < TABLE_SLOTS) ? 5'(i + 1) : NO_SLOT;
			end
			chain_head = NO_SLOT;
			free_head = 5'd0;
			stored_count = 0;
			absent_value = '0;
			mismatch_count = 0;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			mismatch_count++;
		endtask

		// follow a link, any index past the last slot reads as no slot
		function logic [4:0] link_of(logic [4:0] s);
			if (s >= NO_SLOT) return NO_SLOT;
			return (link_mem[s] < NO_SLOT) ? link_mem[s] : NO_SLOT;
		endfunction

		// work out the answer to an accepted request and update the shadow table
		function void note_request(req_t r);
			res_t ans;
			logic [4:0] cur, prev, tail, hit, slot;
			int steps;
			ans.result_value = absent_value;
			ans.found = 1'b0;
			ans.full_res = 1'b0;
			cur = (chain_head < NO_SLOT) ? chain_head : NO_SLOT;
			prev = NO_SLOT;
			tail = NO_SLOT;
			hit = NO_SLOT;
			steps = 0;
			// walk the chain looking for the key
			while (cur < NO_SLOT && steps < TABLE_SLOTS) begin
				if (key_mem[cur] == r.key) begin
					hit = cur;
					break;
				end
				prev = cur;
				tail = cur;
				cur = link_of(cur);
				steps++;
			end
			if (r.mode == MODE_ADD) begin
				if (hit < NO_SLOT) begin
					ans.result_value = val_mem[hit];
					ans.found = 1'b1;
					val_mem[hit] = r.new_value;
				end else if (free_head >= NO_SLOT) begin
					ans.full_res = 1'b1;
				end else begin
					// take the free-list head and append it to the chain
					slot = free_head;
					free_head = link_of(slot);
					key_mem[slot] = r.key;
					val_mem[slot] = r.new_value;
					link_mem[slot] = NO_SLOT;
					if (tail < NO_SLOT) link_mem[tail] = slot;
					else chain_head = slot;
					stored_count++;
				end
			end else if ((r.mode == MODE_SEARCH || r.mode == MODE_REMOVE) && hit < NO_SLOT) begin
				ans.result_value = val_mem[hit];
				ans.found = 1'b1;
				if (r.mode == MODE_REMOVE) begin
					// unlink and push the slot on the free list
					if (prev < NO_SLOT) link_mem[prev] = link_of(hit);
					else chain_head = link_of(hit);
					link_mem[hit] = (free_head < NO_SLOT) ? free_head : NO_SLOT;
					free_head = hit;
					if (stored_count > 0) stored_count--;
				end
			end
			ans.entry_count = 5'(stored_count);
			ans.is_empty = (stored_count == 0);
			expected_answers.push_back(ans);
		endfunction

		// compare one result with the oldest expected answer
		task check_result(res_t got);
			res_t want;
			if (expected_answers.size() == 0) begin
				report($sformatf("result with no request pending: %p", got));
				return;
			end
			want = expected_answers.pop_front();
			if (got.result_value !== want.result_value)
				report($sformatf("result_value %h, expected %h", got.result_value,
					want.result_value));
			if (got.found !== want.found)
				report($sformatf("found %b, expected %b", got.found, want.found));
			if (got.full_res !== want.full_res)
				report($sformatf("full_res %b, expected %b", got.full_res, want.full_res));
			if (got.entry_count !== want.entry_count)
				report($sformatf("entry_count %0d, expected %0d", got.entry_count,
					want.entry_count));
			if (got.is_empty !== want.is_empty)
				report($sformatf("is_empty %b, expected %b", got.is_empty, want.is_empty));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic res_valid;
	res_t res;
	logic psel;
	logic penable;
	logic pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	kv_table_scoreboard sb;
	logic [31:0] key_pool [POOL_SIZE];
	bit idle_on;

	linked_key_value_table_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.res_valid(res_valid),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res_valid) sb.check_result(res);
	end

	// present one request and hold it until the block takes it
	task send_request(input logic [1:0] mode, input logic [31:0] key, input logic [31:0] val);
		req_t r;
		r.mode = mode;
		r.key = key;
		r.new_value = val;
		@(negedge clk);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		sb.note_request(r);
		if (idle_on && $urandom_range(0, 99) < 15) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(0, 24)) @(negedge clk);
		end
	endtask

	// stop sending and let every outstanding result come back
	task wait_drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.expected_answers.size() != 0) @(posedge clk);
		repeat (TABLE_SLOTS + 4) @(posedge clk);
	endtask

	// apb write of absent_value followed by a read back
	task write_absent(input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_ABSENT;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.absent_value = val;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== val)
			sb.report($sformatf("absent_value read back %h, expected %h", prdata, val));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// one random request, add-heavy or remove-heavy
	task send_random(input int add_pct, input int remove_pct);
		int pick;
		logic [1:0] mode;
		logic [31:0] key;
		pick = $urandom_range(0, 99);
		if (pick < 3) mode = MODE_UNUSED;
		else if (pick < 3 + add_pct) mode = MODE_ADD;
		else if (pick < 3 + add_pct + remove_pct) mode = MODE_REMOVE;
		else mode = MODE_SEARCH;
		if ($urandom_range(0, 99) < 6) key = $urandom;
		else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
		send_request(mode, key, $urandom);
	endtask

	// stimulus
	initial begin
		logic [31:0] phase_absent [PHASES];
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_on = 1'b1;
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
		phase_absent[0] = 32'h8000_0000;
		phase_absent[1] = 32'h7fff_ffff;
		phase_absent[2] = 32'hffff_ffff;
		phase_absent[3] = 32'h0000_0000;
		phase_absent[4] = $urandom;
		phase_absent[5] = $urandom;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table with the reset absent value
		send_request(MODE_SEARCH, 32'h0, 32'h0);
		send_request(MODE_REMOVE, 32'h0, 32'h0);
		send_request(MODE_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
		// extreme keys and values, replace, search, remove at the head
		send_request(MODE_ADD, 32'h8000_0000, 32'h7fff_ffff);
		send_request(MODE_ADD, 32'h7fff_ffff, 32'h8000_0000);
		send_request(MODE_ADD, 32'h8000_0000, 32'h1234_5678);
		send_request(MODE_SEARCH, 32'h7fff_ffff, 32'h0);
		send_request(MODE_REMOVE, 32'h8000_0000, 32'h0);
		send_request(MODE_SEARCH, 32'h8000_0000, 32'h0);
		wait_drain();
		write_absent(32'h8000_0000);
		// fill the table, then hit it while full
		for (int i = 0; i < TABLE_SLOTS - 1; i++)
			send_request(MODE_ADD, 32'h5a5a_0000 + i, $urandom);
		send_request(MODE_ADD, 32'h0bad_0001, 32'hdead_beef);
		send_request(MODE_UNUSED, 32'h0, 32'h0);
		send_request(MODE_ADD, 32'h7fff_ffff, 32'h0000_0001);
		// remove from the middle, reuse the freed slot, remove the head
		send_request(MODE_REMOVE, 32'h5a5a_0007, 32'h0);
		send_request(MODE_ADD, 32'h0bad_0001, 32'hcafe_f00d);
		send_request(MODE_REMOVE, 32'h7fff_ffff, 32'h0);

		// random phases alternating between filling and emptying the table
		for (int p = 0; p < PHASES; p++) begin
			wait_drain();
			write_absent(phase_absent[p]);
			idle_on = (p != 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p % 2 == 0) send_random(62, 15);
				else send_random(25, 47);
			end
		end

		wait_drain();
		if (sb.mismatch_count == 0 && sb.expected_answers.size() == 0) begin
			$display("linked_key_value_table_top regression: pass");
		end else begin
			$display("linked_key_value_table_top regression: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#3000000;
		$display("linked_key_value_table_top regression: fail");
		$finish;
	end

endmodule

@@ linked_key_value_table_top.f @@
rtl/lkv_pkg.sv
rtl/lkv_cell.sv
rtl/linked_key_value_table_top.sv
rtl/lkv_checker.sv
tb/linked_key_value_table_top_tb.sv
